/* design/mpds_pkg.sv */
// ----------------------------------------------------------------------------
// mpds_pkg: shared types and constants for the priority decay scheduler
// Field widths, default parameters and the controller/datapath command types.
// ----------------------------------------------------------------------------
`default_nettype none
package mpds_pkg;
    localparam int ID_W        = 6;
    localparam int BURST_IN_W  = 16;
    localparam int PRIO_W      = 4;
    localparam int TIME_W      = 32;
    localparam int D_NUM_PROCS = 64;
    localparam int D_TOP_LEVEL = 10;
    localparam int D_BURST_BITS = 16;

    typedef enum logic {
        REQ_ARRIVE = 1'b0,
        REQ_TICK   = 1'b1
    } t_req;

    typedef struct packed {
        logic req_type;
        logic [ID_W-1:0] proc_id;
        logic [BURST_IN_W-1:0] burst_len;
        logic [PRIO_W-1:0] start_priority;
    } t_in_item;

    typedef struct packed {
        logic idle;
        logic [ID_W-1:0] served_id;
        logic done_res;
        logic first_run;
        logic [TIME_W-1:0] time_now;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic rd;       // issue slot table reads for the latched item
        logic exec;     // commit the latched item
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic makes_result;
    } t_status;
endpackage
`default_nettype wire

/* design/mpds_if.sv */
// ----------------------------------------------------------------------------
// mpds_if: valid/ready channel
// Carries one payload of type T per transfer.
// ----------------------------------------------------------------------------
`default_nettype none
interface mpds_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* design/mpds_ram.sv */
// ----------------------------------------------------------------------------
// mpds_ram: generic single-port-write, one-read RAM
// Registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module mpds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* design/mpds_dp.sv */
// ----------------------------------------------------------------------------
// mpds_dp: scheduler datapath
// Level lists, slot tables, priority encode and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module mpds_dp #(
    parameter int NUM_PROCS  = mpds_pkg::D_NUM_PROCS,
    parameter int TOP_LEVEL  = mpds_pkg::D_TOP_LEVEL,
    parameter int BURST_BITS = mpds_pkg::D_BURST_BITS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_load,
    input  wire mpds_pkg::t_in_item  i_item,
    input  wire mpds_pkg::t_cmd      i_cmd,
    output mpds_pkg::t_status        o_status,
    output mpds_pkg::t_out_item      o_result
);
    import mpds_pkg::*;
    localparam int NLEV = TOP_LEVEL + 1;
    localparam int LW   = $clog2(NLEV);
    localparam int SW   = $clog2(NUM_PROCS);

    t_in_item r_item;
    logic [NUM_PROCS-1:0] r_queued, r_started;
    logic [NLEV-1:0] r_nonempty;
    logic [SW-1:0] r_head [NLEV];
    logic [SW-1:0] r_tail [NLEV];
    logic [TIME_W-1:0] r_ticks;
    t_out_item r_res;

    // tick target, chosen at rd
    logic [LW-1:0] r_lv;
    logic          r_any;
    logic [SW-1:0] r_slot;

    logic [BURST_BITS-1:0] rem_q;
    logic [PRIO_W-1:0]     pri_q;
    logic [SW-1:0]         nxt_q;

    logic          rem_we, pri_we, nxt_we;
    logic [SW-1:0] rem_wa, nxt_wa, rd_addr;
    logic [BURST_BITS-1:0] rem_wd;
    logic [PRIO_W-1:0]     pri_wd;
    logic [SW-1:0]         nxt_wd;

    // priority encode
    logic [LW-1:0] enc_lv;
    logic          enc_any;
    always_comb begin
        enc_lv  = '0;
        enc_any = 1'b0;
        for (int l = 0; l < NLEV; l++) begin
            if (r_nonempty[l]) begin
                enc_lv  = LW'(l);
                enc_any = 1'b1;
            end
        end
    end

    logic [SW-1:0] in_slot;
    logic          in_ok;
    assign in_slot = SW'(r_item.proc_id);
    assign in_ok   = (32'(r_item.proc_id) < NUM_PROCS) && !r_queued[in_slot];

    assign o_status.makes_result = (r_item.req_type == REQ_TICK);
    assign rd_addr = r_head[enc_lv];

    function automatic logic [LW-1:0] lvl_of(input logic [PRIO_W-1:0] p);
        return (32'(p) > TOP_LEVEL) ? LW'(TOP_LEVEL) : LW'(p);
    endfunction

    // tick commit values
    logic done;
    logic [PRIO_W-1:0] npri;
    logic [LW-1:0] plv, alv;
    logic [SW-1:0] ins_slot;
    logic ins_en;
    logic [LW-1:0] ins_lv;
    logic ins_link;
    assign done = (32'(rem_q) <= 1);
    assign npri = (pri_q != '0) ? pri_q - PRIO_W'(1) : pri_q;
    assign plv  = lvl_of(npri);
    assign alv  = lvl_of(r_item.start_priority);

    // link after the old tail when the target list stays non-empty
    assign ins_lv   = (r_item.req_type == REQ_ARRIVE) ? alv : plv;
    assign ins_link = r_nonempty[ins_lv] &&
                      !(r_item.req_type == REQ_TICK && ins_lv == r_lv &&
                        r_tail[r_lv] == r_slot);

    always_comb begin
        rem_we = 1'b0; pri_we = 1'b0; nxt_we = 1'b0;
        rem_wa = r_slot; nxt_wa = '0; nxt_wd = '0;
        rem_wd = done ? '0 : rem_q - BURST_BITS'(1);
        pri_wd = npri;
        ins_en = 1'b0; ins_slot = r_slot;
        if (i_cmd.exec) begin
            if (r_item.req_type == REQ_ARRIVE) begin
                if (in_ok) begin
                    rem_we = 1'b1; pri_we = 1'b1; rem_wa = in_slot;
                    rem_wd = BURST_BITS'(r_item.burst_len);
                    pri_wd = r_item.start_priority;
                    ins_en = 1'b1; ins_slot = in_slot;
                end
            end else if (r_any) begin
                rem_we = 1'b1; pri_we = 1'b1;
                ins_en = !done;
            end
        end
        if (ins_en && ins_link) begin
            nxt_we = 1'b1; nxt_wa = r_tail[ins_lv]; nxt_wd = ins_slot;
        end
    end

    mpds_ram #(.WIDTH(BURST_BITS), .DEPTH(NUM_PROCS)) u_rem (
        .i_clk, .i_we(rem_we), .i_waddr(rem_wa), .i_wdata(rem_wd),
        .i_raddr(rd_addr), .o_rdata(rem_q));
    mpds_ram #(.WIDTH(PRIO_W), .DEPTH(NUM_PROCS)) u_pri (
        .i_clk, .i_we(pri_we), .i_waddr(rem_wa), .i_wdata(pri_wd),
        .i_raddr(rd_addr), .o_rdata(pri_q));
    mpds_ram #(.WIDTH(SW), .DEPTH(NUM_PROCS)) u_nxt (
        .i_clk, .i_we(nxt_we), .i_waddr(nxt_wa), .i_wdata(nxt_wd),
        .i_raddr(rd_addr), .o_rdata(nxt_q));

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
        if (i_cmd.rd) begin
            r_lv   <= enc_lv;
            r_slot <= rd_addr;
        end
        if (i_cmd.exec && r_item.req_type == REQ_TICK) begin
            r_res.idle      <= !r_any;
            r_res.served_id <= r_any ? ID_W'(r_slot) : '0;
            r_res.done_res  <= r_any && done;
            r_res.first_run <= r_any && !r_started[r_slot];
            r_res.time_now  <= r_ticks;
        end
        if (!i_rst_n) begin
            r_queued   <= '0;
            r_started  <= '0;
            r_nonempty <= '0;
            r_ticks    <= '0;
            r_any      <= 1'b0;
        end else begin
            if (i_cmd.rd) begin
                r_any <= enc_any;
            end
            if (i_cmd.exec) begin
                if (r_item.req_type == REQ_TICK) begin
                    r_ticks <= r_ticks + TIME_W'(1);
                    if (r_any) begin
                        if (r_tail[r_lv] == r_slot) begin
                            // a slot requeued on its own level keeps the list live
                            if (!(ins_en && ins_lv == r_lv)) begin
                                r_nonempty[r_lv] <= 1'b0;
                            end
                        end else begin
                            r_head[r_lv] <= nxt_q;
                        end
                        if (done) begin
                            r_queued[r_slot] <= 1'b0;
                        end
                        r_started[r_slot] <= 1'b1;
                    end
                end else if (in_ok) begin
                    r_started[in_slot] <= 1'b0;
                end
                if (ins_en) begin
                    if (!ins_link) begin
                        r_head[ins_lv]     <= ins_slot;
                        r_nonempty[ins_lv] <= 1'b1;
                    end
                    r_tail[ins_lv]     <= ins_slot;
                    r_queued[ins_slot] <= 1'b1;
                end
            end
        end
    end

    assign o_result = r_res;
endmodule
`default_nettype wire

/* design/mpds_ctrl.sv */
// ----------------------------------------------------------------------------
// mpds_ctrl: scheduler controller
// Sequences read and commit of one item and holds the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none
module mpds_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_load,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output mpds_pkg::t_cmd         o_cmd,
    input  wire mpds_pkg::t_status i_status
);
    import mpds_pkg::*;
    typedef enum logic [1:0] {S_IDLE, S_READ, S_EXEC} t_state;
    t_state r_state;
    logic   r_out_valid;

    // a pending result blocks only the commit of another tick
    assign o_in_ready = (r_state == S_IDLE);
    assign o_load     = i_in_valid && o_in_ready;
    assign o_cmd.rd   = (r_state == S_READ);
    assign o_cmd.exec = (r_state == S_EXEC) &&
                        !(i_status.makes_result && r_out_valid && !i_out_ready);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready &&
                !(o_cmd.exec && i_status.makes_result)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: if (o_load) r_state <= S_READ;
                S_READ: r_state <= S_EXEC;
                S_EXEC: begin
                    if (o_cmd.exec) begin
                        r_state <= S_IDLE;
                        if (i_status.makes_result) r_out_valid <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* design/multilevel_priority_decay_scheduler.sv */
// ----------------------------------------------------------------------------
// multilevel_priority_decay_scheduler: multilevel queue scheduler with decay
// Top level: controller, datapath, result handshake.
// ----------------------------------------------------------------------------
// Each item passes through accept, table read and commit; the read of the slot
// tables is registered. A result waits in the output register while the next
// item is taken; a second tick stalls at commit until the earlier result is
// transferred. No clearing pass after reset.
`default_nettype none
module multilevel_priority_decay_scheduler #(
    parameter int NUM_PROCS  = mpds_pkg::D_NUM_PROCS,
    parameter int TOP_LEVEL  = mpds_pkg::D_TOP_LEVEL,
    parameter int BURST_BITS = mpds_pkg::D_BURST_BITS
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    mpds_if.sink     i_req,
    mpds_if.source   o_res
);
    import mpds_pkg::*;
    t_cmd cmd;
    t_status st;
    logic load;

    mpds_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(i_req.valid), .o_in_ready(i_req.ready), .o_load(load),
        .o_out_valid(o_res.valid), .i_out_ready(o_res.ready),
        .o_cmd(cmd), .i_status(st));

    mpds_dp #(.NUM_PROCS(NUM_PROCS), .TOP_LEVEL(TOP_LEVEL), .BURST_BITS(BURST_BITS))
    u_dp (
        .i_clk, .i_rst_n, .i_load(load), .i_item(i_req.data),
        .i_cmd(cmd), .o_status(st), .o_result(o_res.data));

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.rd && cmd.exec)) else $error("read and commit together");
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> cmd.rd) else $error("read did not follow accept");
    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.data.idle) |-> (o_res.data.served_id == '0))
        else $error("idle result with slot");
endmodule
`default_nettype wire
